// File: src/c3rb_pkg.sv
// Package: shared constants and types for the 3x3 replicate-border convolver.
package c3rb_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int SizeW     = 11;
  localparam int PosW      = 10;
  localparam int KernW     = 48;
  localparam int DivW      = 15;
  localparam int CfgW      = 48;
  localparam int IdxW      = 3;

  localparam logic [IdxW-1:0] RegWidth  = 3'd0;
  localparam logic [IdxW-1:0] RegHeight = 3'd1;
  localparam logic [IdxW-1:0] RegTop    = 3'd2;
  localparam logic [IdxW-1:0] RegMid    = 3'd3;
  localparam logic [IdxW-1:0] RegBot    = 3'd4;
  localparam logic [IdxW-1:0] RegDiv    = 3'd5;

  // One pending output: window selection and position.
  typedef struct packed {
    logic [1:0]      lc;
    logic [1:0]      cc;
    logic [1:0]      tr;
    logic [1:0]      mr;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            last;
  } job_t;
endpackage

// File: src/conv3x3_replicate_border_unit.sv
// Top level: 3x3 convolution with replicated borders over a raster pixel stream.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | pixel
//  out     | out_valid | out_stall | value, out_row, out_col, last
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// A pixel passes an accept step (line-memory read), a shift step and a plan
// step. Each of its up to four results then passes a multiply step (nine
// products), a sum step, the restoring divider and an output step. No new
// pixel is taken until the last result of the current one is in the output
// register. Reset is synchronous; line memories are not cleared (entries read
// before written only feed rows the border clamping discards). A stalled
// result holds in the output register and the output step waits for it.
module conv3x3_replicate_border_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             value,
  output logic [c3rb_pkg::PosW-1:0]      out_row,
  output logic [c3rb_pkg::PosW-1:0]      out_col,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic [c3rb_pkg::IdxW-1:0]      cfg_index,
  input  logic [c3rb_pkg::CfgW-1:0]      cfg_data
);
  import c3rb_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StPlan = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  // Configuration registers
  logic [SizeW-1:0] frame_width, frame_height;
  logic [KernW-1:0] kernel_row_top, kernel_row_mid, kernel_row_bot;
  logic [DivW-1:0]  divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= SizeW'(640);
      frame_height   <= SizeW'(480);
      kernel_row_top <= '0;
      kernel_row_mid <= KernW'(65536);
      kernel_row_bot <= '0;
      divisor        <= DivW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        RegWidth:  frame_width    <= cfg_data[SizeW-1:0];
        RegHeight: frame_height   <= cfg_data[SizeW-1:0];
        RegTop:    kernel_row_top <= cfg_data[KernW-1:0];
        RegMid:    kernel_row_mid <= cfg_data[KernW-1:0];
        RegBot:    kernel_row_bot <= cfg_data[KernW-1:0];
        RegDiv:    divisor        <= cfg_data[DivW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes, as last index
  logic [SizeW-1:0] w_eff, h_eff;
  logic [PosW-1:0]  w_last, h_last;
  logic [DivW-1:0]  div_eff;
  always_comb begin
    w_eff = (frame_width == '0) ? SizeW'(1) :
            (frame_width > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : frame_width;
    h_eff = (frame_height == '0) ? SizeW'(1) :
            (frame_height > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : frame_height;
    w_last  = PosW'(w_eff - SizeW'(1));
    h_last  = PosW'(h_eff - SizeW'(1));
    div_eff = (divisor == '0) ? DivW'(1) : divisor;
  end

  logic [2:0]      state;
  logic [PosW-1:0] row_pos, col_pos, r, c;
  logic [7:0]      p;
  logic [7:0]      win [9];
  logic            end_row, last_row;
  job_t            jobs [4];
  logic [2:0]      njobs;
  logic [1:0]      jidx;

  // Line memories: read at accept, write back at shift
  logic [7:0] t_rd, m_rd;
  logic [PosW-1:0] c_in;
  assign c_in = (col_pos > w_last) ? w_last : col_pos;

  c3rb_ram #(.Width(8), .Depth(MaxWidth)) u_two (
    .clk(clk), .we(state == StRead), .waddr(AddrW'(c)), .wdata(m_rd),
    .raddr(AddrW'(c_in)), .rdata(t_rd));
  c3rb_ram #(.Width(8), .Depth(MaxWidth)) u_one (
    .clk(clk), .we(state == StRead), .waddr(AddrW'(c)), .wdata(p),
    .raddr(AddrW'(c_in)), .rdata(m_rd));

  assign in_stall = (state != StIdle);

  // Build the result list for this pixel
  job_t jl [4];
  logic [2:0] jn;
  always_comb begin
    job_t j;
    j = '0;
    jn = 3'd0;
    for (int k = 0; k < 4; k++) jl[k] = '0;
    if (r >= PosW'(1)) begin
      if (c >= PosW'(1)) begin
        j = '0; j.lc = (c == PosW'(1)) ? 2'd1 : 2'd0; j.cc = 2'd1;
        j.tr = (r == PosW'(1)) ? 2'd1 : 2'd0; j.mr = 2'd1;
        j.row = r - PosW'(1); j.col = c - PosW'(1);
        jl[jn[1:0]] = j; jn = jn + 3'd1;
      end
      if (end_row) begin
        j = '0; j.lc = (c == '0) ? 2'd2 : 2'd1; j.cc = 2'd2;
        j.tr = (r == PosW'(1)) ? 2'd1 : 2'd0; j.mr = 2'd1;
        j.row = r - PosW'(1); j.col = c;
        jl[jn[1:0]] = j; jn = jn + 3'd1;
      end
    end
    if (last_row) begin
      if (c >= PosW'(1)) begin
        j = '0; j.lc = (c == PosW'(1)) ? 2'd1 : 2'd0; j.cc = 2'd1;
        j.tr = (r == '0) ? 2'd2 : 2'd1; j.mr = 2'd2;
        j.row = r; j.col = c - PosW'(1);
        jl[jn[1:0]] = j; jn = jn + 3'd1;
      end
      if (end_row) begin
        j = '0; j.lc = (c == '0) ? 2'd2 : 2'd1; j.cc = 2'd2;
        j.tr = (r == '0) ? 2'd2 : 2'd1; j.mr = 2'd2;
        j.row = r; j.col = c;
        jl[jn[1:0]] = j; jn = jn + 3'd1;
      end
    end
    if (jn != 3'd0) jl[2'(jn - 3'd1)].last = 1'b1;
  end

  // Products of the current job
  job_t cj;
  assign cj = jobs[jidx];
  logic signed [24:0] prod [9];
  logic signed [24:0] prod_q [9];
  always_comb begin
    logic [KernW-1:0] kr;
    logic [1:0] ci, ri;
    for (int i = 0; i < 3; i++) begin
      kr = (i == 0) ? kernel_row_top : (i == 1) ? kernel_row_mid : kernel_row_bot;
      ri = (i == 0) ? cj.tr : (i == 1) ? cj.mr : 2'd2;
      for (int k = 0; k < 3; k++) begin
        ci = (k == 0) ? cj.lc : (k == 1) ? cj.cc : 2'd2;
        prod[i*3+k] = $signed(kr[16*k +: 16]) *
                      $signed({1'b0, win[4'(ci) * 4'd3 + 4'(ri)]});
      end
    end
  end

  logic [15:0] sum16;
  always_comb begin
    sum16 = '0;
    for (int k = 0; k < 9; k++) sum16 = sum16 + prod_q[k][15:0];
  end

  // Restoring divider on magnitudes
  logic [15:0] quo, rem_s;
  logic [15:0] dvd;
  logic        neg;
  logic [3:0]  bitn;
  logic [16:0] trial;
  assign trial = {rem_s, dvd[15]} - {2'b0, div_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle; row_pos <= '0; col_pos <= '0; out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else begin
      case (state)
        StIdle: if (in_valid) begin
          p <= pixel; r <= row_pos; c <= c_in;
          end_row  <= (c_in >= w_last);
          last_row <= (row_pos >= h_last);
          state <= StRead;
        end
        StRead: begin
          for (int k = 0; k < 6; k++) win[k] <= win[k+3];
          win[6] <= t_rd; win[7] <= m_rd; win[8] <= p;
          if (end_row) begin
            col_pos <= '0;
            row_pos <= last_row ? '0 : r + PosW'(1);
          end else col_pos <= c + PosW'(1);
          state <= StPlan;
        end
        StPlan: begin
          for (int k = 0; k < 4; k++) jobs[k] <= jl[k];
          njobs <= jn; jidx <= '0;
          state <= (jn == 3'd0) ? StIdle : StMul;
        end
        StMul: begin
          for (int k = 0; k < 9; k++) prod_q[k] <= prod[k];
          state <= StSum;
        end
        StSum: begin
          neg  <= sum16[15];
          dvd  <= sum16[15] ? 16'(-sum16) : sum16;
          rem_s <= '0; quo <= '0; bitn <= '0;
          state <= StDiv;
        end
        StDiv: begin
          if (!trial[16]) begin
            rem_s <= trial[15:0]; quo <= {quo[14:0], 1'b1};
          end else begin
            rem_s <= {rem_s[14:0], dvd[15]}; quo <= {quo[14:0], 1'b0};
          end
          dvd <= {dvd[14:0], 1'b0};
          bitn <= bitn + 4'd1;
          if (bitn == 4'd15) state <= StOut;
        end
        StOut: begin
          if (!out_valid || !out_stall) begin
            value <= neg ? -$signed(quo) : $signed(quo);
            out_row <= cj.row; out_col <= cj.col; last <= cj.last;
            out_valid <= 1'b1;
            jidx <= jidx + 2'd1;
            state <= (3'(jidx) + 3'd1 == njobs) ? StIdle : StMul;
          end
        end
        default: state <= StIdle;
      endcase
      if (out_valid && !out_stall && !(state == StOut)) out_valid <= 1'b0;
    end
  end
endmodule

// File: src/c3rb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module c3rb_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: bench/tb_conv3x3_replicate_border_unit.sv
// Testbench for the 3x3 replicate-border convolver: directed and random frames checked against a predictor.
`timescale 1ns / 100ps

class conv_scoreboard;
  int unsigned fw, fh;
  logic [47:0] krow [3];
  int unsigned dv;
  logic [7:0] ln2 [1024];
  logic [7:0] ln1 [1024];
  logic [7:0] win [9];
  int unsigned rpos, cpos;
  logic [36:0] pending [$];
  int errors;
  int shown;

  function new();
    fw = 640; fh = 480; krow[0] = 0; krow[1] = 48'h10000; krow[2] = 0; dv = 1;
    foreach (ln2[i]) begin
      ln2[i] = 0;
      ln1[i] = 0;
    end
    foreach (win[i]) win[i] = 0;
    rpos = 0; cpos = 0; errors = 0; shown = 0;
  endfunction

  function void set_reg(int idx, logic [47:0] d);
    case (idx)
      0: fw = d[10:0];
      1: fh = d[10:0];
      2: krow[0] = d;
      3: krow[1] = d;
      4: krow[2] = d;
      5: dv = d[14:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] filt(int lc, int cc, int rc, int tr, int mr, int br);
    int cols [3];
    int rows [3];
    int sum;
    int s16;
    int d;
    logic [15:0] k;
    cols[0] = lc; cols[1] = cc; cols[2] = rc;
    rows[0] = tr; rows[1] = mr; rows[2] = br;
    sum = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        k = krow[i][16*j +: 16];
        sum += int'($signed(k)) * int'(win[(cols[j]*3 + rows[i]) % 9]);
      end
    s16 = int'($signed(sum[15:0]));
    d = (dv == 0) ? 1 : dv;
    return 16'(s16 / d);
  endfunction

  function void push(logic [15:0] v, int r, int c);
    pending.push_back({v, 10'(r), 10'(c), 1'b0});
  endfunction

  // Note an accepted pixel and queue the outputs it completes.
  function void note_pixel(logic [7:0] p);
    int unsigned w, h, r, c;
    int n0, tr, lc;
    bit er, lr;
    logic [7:0] t, m;
    logic [36:0] e;
    w = (fw == 0) ? 1 : (fw > 1024 ? 1024 : fw);
    h = (fh == 0) ? 1 : (fh > 1024 ? 1024 : fh);
    r = rpos; c = cpos;
    if (c >= w) c = w - 1;
    er = (c >= w - 1);
    lr = (r >= h - 1);
    t = ln2[c]; m = ln1[c];
    ln2[c] = m; ln1[c] = p;
    for (int k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = t; win[7] = m; win[8] = p;
    n0 = pending.size();
    if (r >= 1) begin
      tr = (r == 1) ? 1 : 0;
      if (c >= 1) begin
        lc = (c == 1) ? 1 : 0;
        push(filt(lc, 1, 2, tr, 1, 2), r - 1, c - 1);
      end
      if (er) begin
        lc = (c == 0) ? 2 : 1;
        push(filt(lc, 2, 2, tr, 1, 2), r - 1, c);
      end
    end
    if (lr) begin
      tr = (r == 0) ? 2 : 1;
      if (c >= 1) begin
        lc = (c == 1) ? 1 : 0;
        push(filt(lc, 1, 2, tr, 2, 2), r, c - 1);
      end
      if (er) begin
        lc = (c == 0) ? 2 : 1;
        push(filt(lc, 2, 2, tr, 2, 2), r, c);
      end
    end
    if (pending.size() > n0) begin
      e = pending.pop_back();
      e[0] = 1'b1;
      pending.push_back(e);
    end
    if (er) begin
      cpos = 0;
      rpos = lr ? 0 : ((r + 1) & 10'h3ff);
    end else begin
      cpos = (c + 1) & 10'h3ff;
    end
  endfunction

  // Compare one accepted result beat with the oldest expectation.
  function void check_result(logic [15:0] v, logic [9:0] r, logic [9:0] c, logic l);
    logic [36:0] e;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result value=%0d row=%0d col=%0d", $signed(v), r, c);
      end
      return;
    end
    e = pending.pop_front();
    if (e != {v, r, c, l}) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch exp v=%0d r=%0d c=%0d l=%0b got v=%0d r=%0d c=%0d l=%0b",
                 $signed(e[36:21]), e[20:11], e[10:1], e[0], $signed(v), r, c, l);
      end
    end
  endfunction
endclass

module tb_conv3x3_replicate_border_unit;
  import c3rb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] pixel = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] value;
  logic [PosW-1:0] out_row, out_col;
  logic last;
  logic cfg_we = 0;
  logic [IdxW-1:0] cfg_index = RegWidth;
  logic [CfgW-1:0] cfg_data = 0;

  conv_scoreboard sb;
  bit idle_ok = 1;
  bit hold_rx = 0;

  conv3x3_replicate_border_unit DUT (.*);

  always #5 clk = ~clk;

  // Sample result beats.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(value, out_row, out_col, last);
  end

  // Receiver stall: random bursts, or a long forced hold.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_rx) begin
        @(posedge clk);
        out_stall <= 1;
      end else if (idle_ok && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        repeat (n) begin
          @(posedge clk);
          out_stall <= 1;
        end
      end else begin
        @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] d);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, d);
  endtask

  // Offer one pixel; valid stays high after the beat until the next idle or drain.
  task automatic send_pixel(logic [7:0] p);
    int n;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1; pixel <= p;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
  endtask

  // Drop valid, wait for all outputs and a latency tail before touching registers.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_kern(bit big);
    logic [47:0] k;
    for (int j = 0; j < 3; j++)
      k[16*j +: 16] = big ? 16'($urandom) : 16'($signed($urandom_range(0, 8)) - 4);
    return k;
  endfunction

  task automatic frame(int w, int h, bit noisy);
    write_reg(RegWidth, CfgW'(w));
    write_reg(RegHeight, CfgW'(h));
    for (int i = 0; i < w * h; i++)
      send_pixel(noisy ? 8'($urandom) : 8'($urandom_range(100, 140)));
    drain();
  endtask

  initial begin
    int cnt;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // Directed: identity kernel on a tiny frame, pixel extremes.
    write_reg(RegWidth, CfgW'(3));
    write_reg(RegHeight, CfgW'(2));
    send_pixel(8'h00); send_pixel(8'hff); send_pixel(8'h55);
    send_pixel(8'haa); send_pixel(8'hff); send_pixel(8'h00);
    drain();
    // Extreme coefficients and divisors.
    write_reg(RegTop, 48'h7fff_8000_7fff);
    write_reg(RegMid, 48'h8000_7fff_8000);
    write_reg(RegBot, 48'hffff_ffff_ffff);
    write_reg(RegDiv, CfgW'(1));
    frame(1, 1, 1);
    frame(1, 3, 1);
    write_reg(RegDiv, CfgW'(15'h7fff));
    frame(3, 1, 1);
    write_reg(RegDiv, CfgW'(0));
    write_reg(RegWidth, CfgW'(0));
    write_reg(RegHeight, CfgW'(0));
    send_pixel(8'h80);
    drain();
    write_reg(RegDiv, CfgW'(7));
    frame(2, 2, 1);

    // Back pressure: receiver holds long while the sender keeps going.
    write_reg(RegTop, rand_kern(0));
    write_reg(RegMid, rand_kern(0));
    write_reg(RegBot, rand_kern(0));
    write_reg(RegDiv, CfgW'(3));
    write_reg(RegWidth, CfgW'(4));
    write_reg(RegHeight, CfgW'(3));
    fork
      begin
        hold_rx = 1;
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 12; i++) send_pixel(8'($urandom));
    join
    drain();

    // Random frames, small sizes, varying settings.
    cnt = 0;
    while (cnt < 120) begin
      int w, h;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      write_reg(RegTop, rand_kern($urandom_range(0, 1)));
      write_reg(RegMid, rand_kern($urandom_range(0, 1)));
      write_reg(RegBot, rand_kern($urandom_range(0, 1)));
      write_reg(RegDiv, CfgW'($urandom_range(0, 3) == 0 ? $urandom_range(1, 32767)
                                                        : $urandom_range(1, 9)));
      if (cnt > 90) idle_ok = 0;
      frame(w, h, $urandom_range(0, 1));
      cnt += w * h;
    end
    // Oversized width saturates; a narrower width then ends the row at once.
    write_reg(RegTop, 48'h0);
    write_reg(RegMid, 48'h10000);
    write_reg(RegBot, 48'h0);
    write_reg(RegDiv, CfgW'(1));
    write_reg(RegWidth, CfgW'(1100));
    write_reg(RegHeight, CfgW'(1));
    send_pixel(8'($urandom)); send_pixel(8'($urandom)); send_pixel(8'($urandom));
    drain();
    write_reg(RegWidth, CfgW'(3));
    send_pixel(8'($urandom));
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: sim.f
src/c3rb_pkg.sv
src/c3rb_ram.sv
src/conv3x3_replicate_border_unit.sv
bench/tb_conv3x3_replicate_border_unit.sv
